// ===== sv/phs_pkg.sv =====
// Shared types and constants for the particle heat-map splat block.
`default_nettype none

package phs_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_FACTOR = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_X     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_Y     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_MAX    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_SCALE    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_LIMIT      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_LIMIT      = 3'd6;

   // Register reset values
   localparam logic [31:0] SCALE_FACTOR_RESET = 32'd65536;
   localparam logic [31:0] OFFSET_RESET       = 32'd0;
   localparam logic [31:0] RANGE_MAX_RESET    = 32'd65536;
   localparam logic [31:0] HUE_SCALE_RESET    = 32'd43691;
   localparam logic [31:0] X_LIMIT_RESET      = 32'd640;
   localparam logic [31:0] Y_LIMIT_RESET      = 32'd480;

   // Hue arithmetic
   localparam logic [16:0] HUE_ONE     = 17'h10000;
   localparam logic [7:0]  COLOR_FULL  = 8'hFF;
   localparam logic [7:0]  COLOR_NONE  = 8'h00;
   localparam logic [2:0]  SECTOR_WRAP = 3'd6;

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Beats per splat
   localparam logic [1:0] LAST_BEAT = 2'd3;

   // Color wheel sectors, 60 degrees each
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

endpackage

`default_nettype wire

// ===== sv/phs_front.sv =====
// Front end: config registers, coordinate and hue pipeline, window classification.
`default_nettype none

module phs_front #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wen,
   input  wire logic [phs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [31:0]                            csr_wdata,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [31:0]                     req_pos_x,
   input  wire logic signed [31:0]                     req_pos_y,
   input  wire logic signed [31:0]                     req_prop_value,
   output logic                                        push_valid,
   input  wire logic                                   push_ready,
   output logic [PIXEL_COORD_BITS-1:0]                 push_px,
   output logic [PIXEL_COORD_BITS-1:0]                 push_py,
   output phs_pkg::rgb_type                            push_color
);

   localparam int PCB = PIXEL_COORD_BITS;

   // Configuration registers
   logic [31:0]    scale_factor_ff;
   logic [31:0]    offset_x_ff;
   logic [31:0]    offset_y_ff;
   logic [31:0]    range_max_ff;
   logic [31:0]    hue_scale_ff;
   logic [PCB-1:0] x_limit_ff;
   logic [PCB-1:0] y_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= phs_pkg::SCALE_FACTOR_RESET;
         offset_x_ff     <= phs_pkg::OFFSET_RESET;
         offset_y_ff     <= phs_pkg::OFFSET_RESET;
         range_max_ff    <= phs_pkg::RANGE_MAX_RESET;
         hue_scale_ff    <= phs_pkg::HUE_SCALE_RESET;
         x_limit_ff      <= phs_pkg::X_LIMIT_RESET[PCB-1:0];
         y_limit_ff      <= phs_pkg::Y_LIMIT_RESET[PCB-1:0];
      end else if (csr_wen) begin
         case (csr_index)
            phs_pkg::CSR_SCALE_FACTOR: scale_factor_ff <= csr_wdata;
            phs_pkg::CSR_OFFSET_X:     offset_x_ff     <= csr_wdata;
            phs_pkg::CSR_OFFSET_Y:     offset_y_ff     <= csr_wdata;
            phs_pkg::CSR_RANGE_MAX:    range_max_ff    <= csr_wdata;
            phs_pkg::CSR_HUE_SCALE:    hue_scale_ff    <= csr_wdata;
            phs_pkg::CSR_X_LIMIT:      x_limit_ff      <= csr_wdata[PCB-1:0];
            phs_pkg::CSR_Y_LIMIT:      y_limit_ff      <= csr_wdata[PCB-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline moves together; it holds only when the last stage cannot push
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic advance;

   assign advance   = !(v4_ff && !push_ready);
   assign req_ready = advance;

   // Stage 1: exact 33-bit differences, magnitude picked from both orders
   logic [32:0] dx_fwd, dx_rev, dy_fwd, dy_rev, dh;
   logic [31:0] mag_x_in, mag_y_in, dmag_in;
   logic        neg_x_in, neg_y_in, dpos_in;
   logic [31:0] mag_x_ff, mag_y_ff, dmag_ff;
   logic        neg_x_ff, neg_y_ff, dpos_ff;

   always_comb begin
      dx_fwd   = {req_pos_x[31], req_pos_x} - {offset_x_ff[31], offset_x_ff};
      dx_rev   = {offset_x_ff[31], offset_x_ff} - {req_pos_x[31], req_pos_x};
      dy_fwd   = {req_pos_y[31], req_pos_y} - {offset_y_ff[31], offset_y_ff};
      dy_rev   = {offset_y_ff[31], offset_y_ff} - {req_pos_y[31], req_pos_y};
      dh       = {range_max_ff[31], range_max_ff} - {req_prop_value[31], req_prop_value};
      neg_x_in = dx_fwd[32];
      neg_y_in = dy_fwd[32];
      mag_x_in = neg_x_in ? dx_rev[31:0] : dx_fwd[31:0];
      mag_y_in = neg_y_in ? dy_rev[31:0] : dy_fwd[31:0];
      dpos_in  = !dh[32] && (dh[31:0] != 32'd0);
      dmag_in  = dh[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         neg_x_ff <= neg_x_in;
         neg_y_ff <= neg_y_in;
         dmag_ff  <= dmag_in;
         dpos_ff  <= dpos_in;
      end
   end

   // Stage 2: three 32x32 multiplies
   logic [63:0] prod_x, prod_y, prod_h;
   logic [31:0] whole_x_ff, whole_y_ff;
   logic        neg_x2_ff, neg_y2_ff, dpos2_ff;
   logic [47:0] hue_raw_ff;

   always_comb begin
      prod_x = mag_x_ff * scale_factor_ff;
      prod_y = mag_y_ff * scale_factor_ff;
      prod_h = dmag_ff * hue_scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         whole_x_ff <= prod_x[63:32];
         whole_y_ff <= prod_y[63:32];
         neg_x2_ff  <= neg_x_ff;
         neg_y2_ff  <= neg_y_ff;
         hue_raw_ff <= prod_h[63:16];
         dpos2_ff   <= dpos_ff;
      end
   end

   // Stage 3: window check, hue clamp, sector and fraction
   logic [31:0]          x_lim_wide, y_lim_wide;
   logic                 in_x, in_y;
   logic [16:0]          hue;
   logic [18:0]          hue6;
   logic                 keep3_in;
   logic [PCB-1:0]       px3_in, py3_in;
   phs_pkg::sector_type  sector3_in;
   logic [16:0]          frac3_in;
   logic                 keep3_ff;
   logic [PCB-1:0]       px3_ff, py3_ff;
   phs_pkg::sector_type  sector3_ff;
   logic [16:0]          frac3_ff;

   always_comb begin
      x_lim_wide = {{(32-PCB){1'b0}}, x_limit_ff};
      y_lim_wide = {{(32-PCB){1'b0}}, y_limit_ff};
      // a negative offset that truncates to zero lands on pixel zero
      in_x = neg_x2_ff ? ((whole_x_ff == 32'd0) && (x_limit_ff != '0))
                       : (whole_x_ff < x_lim_wide);
      in_y = neg_y2_ff ? ((whole_y_ff == 32'd0) && (y_limit_ff != '0))
                       : (whole_y_ff < y_lim_wide);
      keep3_in = in_x && in_y;
      px3_in   = neg_x2_ff ? '0 : whole_x_ff[PCB-1:0];
      py3_in   = neg_y2_ff ? '0 : whole_y_ff[PCB-1:0];

      if (!dpos2_ff) begin
         hue = 17'd0;
      end else if (hue_raw_ff > {31'd0, phs_pkg::HUE_ONE}) begin
         hue = phs_pkg::HUE_ONE;
      end else begin
         hue = hue_raw_ff[16:0];
      end
      hue6 = {hue, 2'b00} + {1'b0, hue, 1'b0};
      // full hue folds into the last sector with a full fraction
      if (hue6[18:16] == phs_pkg::SECTOR_WRAP) begin
         sector3_in = phs_pkg::SEC_MAG_RED;
         frac3_in   = phs_pkg::HUE_ONE;
      end else begin
         sector3_in = phs_pkg::sector_type'(hue6[18:16]);
         frac3_in   = {1'b0, hue6[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         keep3_ff   <= keep3_in;
         px3_ff     <= px3_in;
         py3_ff     <= py3_in;
         sector3_ff <= sector3_in;
         frac3_ff   <= frac3_in;
      end
   end

   // Stage 4: ramp values and color select; dropped particles leave here
   logic [24:0]      ramp_up, ramp_dn;
   logic [16:0]      frac_inv;
   logic [7:0]       t_val, q_val;
   phs_pkg::rgb_type color4_in;
   logic [PCB-1:0]   px4_ff, py4_ff;
   phs_pkg::rgb_type color4_ff;

   always_comb begin
      frac_inv = phs_pkg::HUE_ONE - frac3_ff;
      ramp_up  = {frac3_ff, 8'd0} - {8'd0, frac3_ff};
      ramp_dn  = {frac_inv, 8'd0} - {8'd0, frac_inv};
      t_val    = ramp_up[23:16];
      q_val    = ramp_dn[23:16];
      case (sector3_ff)
         phs_pkg::SEC_RED_YEL: color4_in = '{phs_pkg::COLOR_FULL, t_val, phs_pkg::COLOR_NONE};
         phs_pkg::SEC_YEL_GRN: color4_in = '{q_val, phs_pkg::COLOR_FULL, phs_pkg::COLOR_NONE};
         phs_pkg::SEC_GRN_CYN: color4_in = '{phs_pkg::COLOR_NONE, phs_pkg::COLOR_FULL, t_val};
         phs_pkg::SEC_CYN_BLU: color4_in = '{phs_pkg::COLOR_NONE, q_val, phs_pkg::COLOR_FULL};
         phs_pkg::SEC_BLU_MAG: color4_in = '{t_val, phs_pkg::COLOR_NONE, phs_pkg::COLOR_FULL};
         default:              color4_in = '{phs_pkg::COLOR_FULL, phs_pkg::COLOR_NONE, q_val};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff && keep3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px4_ff    <= px3_ff;
         py4_ff    <= py3_ff;
         color4_ff <= color4_in;
      end
   end

   assign push_valid = v4_ff;
   assign push_px    = px4_ff;
   assign push_py    = py4_ff;
   assign push_color = color4_ff;

`ifndef SYNTHESIS
   // a particle outside the window never reaches the queue
   a_drop_no_push: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !keep3_ff && advance) |=> !v4_ff)
      else $error("dropped particle reached the queue stage");
`endif

endmodule

`default_nettype wire

// ===== sv/phs_queue.sv =====
// Short queue of classified splats between front and back.
`default_nettype none

module phs_queue #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   output logic                               push_ready,
   input  wire logic [PIXEL_COORD_BITS-1:0]   push_px,
   input  wire logic [PIXEL_COORD_BITS-1:0]   push_py,
   input  wire phs_pkg::rgb_type              push_color,
   output logic                               pop_valid,
   input  wire logic                          pop_ready,
   output logic [PIXEL_COORD_BITS-1:0]        pop_px,
   output logic [PIXEL_COORD_BITS-1:0]        pop_py,
   output phs_pkg::rgb_type                   pop_color
);

   localparam int PCB = PIXEL_COORD_BITS;

   logic [PCB-1:0]                        px_q    [phs_pkg::QUEUE_DEPTH];
   logic [PCB-1:0]                        py_q    [phs_pkg::QUEUE_DEPTH];
   phs_pkg::rgb_type                      color_q [phs_pkg::QUEUE_DEPTH];
   logic [phs_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [phs_pkg::QUEUE_CNT_BITS-1:0]    count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != phs_pkg::QUEUE_CNT_BITS'(phs_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   assign pop_px    = px_q[rd_ptr_ff];
   assign pop_py    = py_q[rd_ptr_ff];
   assign pop_color = color_q[rd_ptr_ff];

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         px_q[wr_ptr_ff]    <= push_px;
         py_q[wr_ptr_ff]    <= push_py;
         color_q[wr_ptr_ff] <= push_color;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= phs_pkg::QUEUE_CNT_BITS'(phs_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   a_pop_only_dec: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

// ===== sv/phs_back.sv =====
// Back end: expands one queued splat into four pixel beats.
`default_nettype none

module phs_back #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire logic [PIXEL_COORD_BITS-1:0]   pop_px,
   input  wire logic [PIXEL_COORD_BITS-1:0]   pop_py,
   input  wire phs_pkg::rgb_type              pop_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [PIXEL_COORD_BITS-1:0]        rsp_pix_x,
   output logic [PIXEL_COORD_BITS-1:0]        rsp_pix_y,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   output logic                               rsp_last_pixel
);

   localparam int PCB = PIXEL_COORD_BITS;

   logic                 busy_ff;
   logic [1:0]           beat_ff;
   logic [PCB-1:0]       px_ff, py_ff;
   phs_pkg::rgb_type     color_ff;
   logic                 last_beat;
   logic                 beat_done;

   assign last_beat = (beat_ff == phs_pkg::LAST_BEAT);
   assign beat_done = busy_ff && rsp_ready;
   // load the next splat while the last beat of this one goes out
   assign pop_ready = !busy_ff || (beat_done && last_beat);

   // Beat sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else if (pop_valid && pop_ready) begin
         busy_ff <= 1'b1;
         beat_ff <= '0;
      end else if (beat_done) begin
         if (last_beat) begin
            busy_ff <= 1'b0;
         end else begin
            beat_ff <= beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         px_ff    <= pop_px;
         py_ff    <= pop_py;
         color_ff <= pop_color;
      end
   end

   // Beat order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
   assign rsp_valid      = busy_ff;
   assign rsp_pix_x      = px_ff + PCB'(beat_ff[0]);
   assign rsp_pix_y      = py_ff + PCB'(beat_ff[1]);
   assign rsp_red        = color_ff.red;
   assign rsp_green      = color_ff.green;
   assign rsp_blue       = color_ff.blue;
   assign rsp_last_pixel = last_beat;

`ifndef SYNTHESIS
   a_splat_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_pixel)
         |=> (rsp_valid && beat_ff == $past(beat_ff) + 1'b1))
      else $error("splat cut short before its fourth beat");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_pixel && !pop_valid) |=> !rsp_valid)
      else $error("beat emitted with no queued splat");
`endif

endmodule

`default_nettype wire

// ===== sv/particle_heatmap_splat.sv =====
// Top level of the particle heat-map splat: front pipeline, queue and beat generator.
//
//  Port group   Role                          Handshake
//  req_*        particle in (x, y, property)  valid / ready
//  rsp_*        pixel write out, 4 per splat  valid / ready
//  csr_*        register write                csr_wen, no wait
//
// A particle passes a four-stage front pipeline (differences, multiplies, window
// check and hue, color) and lands in a four-entry queue; particles can enter
// every cycle until the queue fills. The back end gives four beats per kept
// particle and takes the next splat on the last beat, so the result port sets
// the sustained rate. Reset is synchronous, clears all valid state and loads
// the registers with their reset values; a stall on rsp_ready holds the queue,
// and the front pipeline stalls only when the queue is full.
`default_nettype none

module particle_heatmap_splat #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [phs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [31:0]                         csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [31:0]                  req_pos_x,
   input  wire logic signed [31:0]                  req_pos_y,
   input  wire logic signed [31:0]                  req_prop_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [PIXEL_COORD_BITS-1:0]              rsp_pix_x,
   output logic [PIXEL_COORD_BITS-1:0]              rsp_pix_y,
   output logic [7:0]                               rsp_red,
   output logic [7:0]                               rsp_green,
   output logic [7:0]                               rsp_blue,
   output logic                                     rsp_last_pixel
);

   logic                          push_valid, push_ready;
   logic [PIXEL_COORD_BITS-1:0]   push_px, push_py;
   phs_pkg::rgb_type              push_color;
   logic                          pop_valid, pop_ready;
   logic [PIXEL_COORD_BITS-1:0]   pop_px, pop_py;
   phs_pkg::rgb_type              pop_color;

   phs_front #(
      .PIXEL_COORD_BITS (PIXEL_COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_prop_value (req_prop_value),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_px        (push_px),
      .push_py        (push_py),
      .push_color     (push_color)
   );

   phs_queue #(
      .PIXEL_COORD_BITS (PIXEL_COORD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_px    (push_px),
      .push_py    (push_py),
      .push_color (push_color),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_px     (pop_px),
      .pop_py     (pop_py),
      .pop_color  (pop_color)
   );

   phs_back #(
      .PIXEL_COORD_BITS (PIXEL_COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_px         (pop_px),
      .pop_py         (pop_py),
      .pop_color      (pop_color),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pix_x      (rsp_pix_x),
      .rsp_pix_y      (rsp_pix_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

`default_nettype wire
